@@ hdl/oets_pkg.sv @@
// ----------------------------------------------------------------------------
// Odd-even transposition sort package
// Shared sizes, cell commands and controller states for the sorter.
// ----------------------------------------------------------------------------
package oets_pkg;

  localparam int MaxElements = 16;
  localparam int DataW       = 8;
  localparam int CfgW        = 5;
  localparam int CountW      = $clog2(MaxElements + 1);
  localparam int SizeW       = (CountW > CfgW) ? CountW : CfgW;

  typedef logic [DataW-1:0] data_t;
  typedef logic [CountW-1:0] count_t;

  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_SHIFT_UP,
    CELL_SHIFT_DOWN,
    CELL_TAKE_MIN,
    CELL_TAKE_MAX
  } cell_cmd_e;

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_SORT,
    ST_EMIT
  } state_e;

endpackage

@@ hdl/oets_cell.sv @@
// ----------------------------------------------------------------------------
// Sorter cell
// Holds one byte of the set and loads, shifts or compare-exchanges it with a
// neighbour as commanded.
// ----------------------------------------------------------------------------
module oets_cell
  import oets_pkg::*;
(
  input  logic      clk_i,
  input  cell_cmd_e cmd_i,
  input  data_t     left_i,
  input  data_t     right_i,
  output data_t     value_o
);

  data_t value_d, value_q;

  always_comb begin
    unique case (cmd_i)
      CELL_HOLD:       value_d = value_q;
      CELL_SHIFT_UP:   value_d = left_i;
      CELL_SHIFT_DOWN: value_d = right_i;
      CELL_TAKE_MIN:   value_d = (right_i < value_q) ? right_i : value_q;
      CELL_TAKE_MAX:   value_d = (left_i > value_q) ? left_i : value_q;
      default:         value_d = value_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

  assign value_o = value_q;

endmodule

@@ hdl/odd_even_transposition_sort.sv @@
// ----------------------------------------------------------------------------
// Odd-even transposition sorter
// Collects a set of bytes, sorts them in a row of cells and streams them out
// in ascending order.
// ----------------------------------------------------------------------------
// Usage: bytes enter on value_i with in_valid_i; a request is taken when
// in_stall_o is low. Once set_size bytes have arrived (a size of zero counts
// as one, sizes above the row length are clipped to it), the input stalls
// while the row of cells runs one compare-exchange phase per cycle, n phases
// for a set of n bytes. The sorted bytes then leave on sorted_value_o with
// out_valid_o, smallest first, last_o marking the largest. A request on the
// output is taken when out_stall_i is low; while it is high the output holds.
// A set of n bytes is loaded, sorted and emitted in turn by the single row of
// cells that is shared by all three steps, so the input stalls until the last
// byte has left or set_size is written. The first result appears once the
// sort phases are done. Reset empties the set and restores a set size of
// sixteen. Writing set_size discards a partly loaded set.
// ----------------------------------------------------------------------------
module odd_even_transposition_sort
  import oets_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  logic [CfgW-1:0] cfg_data_i,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  logic [7:0]      value_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output logic [7:0]      sorted_value_o,
  output logic            last_o
);

  state_e          state_d, state_q;
  logic [CfgW-1:0] size_d, size_q;
  count_t          load_cnt_d, load_cnt_q;
  count_t          phase_cnt_d, phase_cnt_q;
  logic [SizeW-1:0] size_ext;
  count_t          n_eff;
  count_t          n_last;
  logic            in_acc, out_acc;

  cell_cmd_e cmd    [MaxElements];
  data_t     cell_q [MaxElements];
  data_t     left_v [MaxElements];
  data_t     right_v[MaxElements];

  assign size_ext = SizeW'(size_q);

  always_comb begin
    if (size_ext == '0) begin
      n_eff = count_t'(1);
    end else if (size_ext > SizeW'(MaxElements)) begin
      n_eff = count_t'(MaxElements);
    end else begin
      n_eff = count_t'(size_ext);
    end
  end

  assign n_last  = n_eff - count_t'(1);
  assign in_acc  = in_valid_i && !in_stall_o;
  assign out_acc = out_valid_o && !out_stall_i;

  always_comb begin
    state_d     = state_q;
    size_d      = size_q;
    load_cnt_d  = load_cnt_q;
    phase_cnt_d = phase_cnt_q;
    unique case (state_q)
      ST_LOAD: begin
        if (in_acc) begin
          if (load_cnt_q == n_last) begin
            load_cnt_d = '0;
            state_d    = ST_SORT;
          end else begin
            load_cnt_d = load_cnt_q + count_t'(1);
          end
        end
      end
      ST_SORT: begin
        if (phase_cnt_q == n_last) begin
          phase_cnt_d = '0;
          state_d     = ST_EMIT;
        end else begin
          phase_cnt_d = phase_cnt_q + count_t'(1);
        end
      end
      ST_EMIT: begin
        if (out_acc) begin
          if (phase_cnt_q == n_last) begin
            phase_cnt_d = '0;
            state_d     = ST_LOAD;
          end else begin
            phase_cnt_d = phase_cnt_q + count_t'(1);
          end
        end
      end
      default: state_d = ST_LOAD;
    endcase
    if (cfg_we_i) begin
      size_d      = cfg_data_i;
      load_cnt_d  = '0;
      phase_cnt_d = '0;
      state_d     = ST_LOAD;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_LOAD;
      size_q      <= CfgW'(16);
      load_cnt_q  <= '0;
      phase_cnt_q <= '0;
    end else begin
      state_q     <= state_d;
      size_q      <= size_d;
      load_cnt_q  <= load_cnt_d;
      phase_cnt_q <= phase_cnt_d;
    end
  end

  always_comb begin
    for (int i = 0; i < MaxElements; i++) begin
      cmd[i] = CELL_HOLD;
      unique case (state_q)
        ST_LOAD: begin
          if (in_acc) begin
            cmd[i] = CELL_SHIFT_UP;
          end
        end
        ST_SORT: begin
          if ((1'(i) == phase_cnt_q[0]) && (count_t'(i + 1) < n_eff)) begin
            cmd[i] = CELL_TAKE_MIN;
          end else if ((i >= 1) && (1'(i - 1) == phase_cnt_q[0]) &&
                       (count_t'(i) < n_eff)) begin
            cmd[i] = CELL_TAKE_MAX;
          end
        end
        ST_EMIT: begin
          if (out_acc) begin
            cmd[i] = CELL_SHIFT_DOWN;
          end
        end
        default: cmd[i] = CELL_HOLD;
      endcase
    end
  end

  always_comb begin
    for (int i = 0; i < MaxElements; i++) begin
      left_v[i]  = (i == 0) ? value_i : cell_q[(i == 0) ? 0 : i - 1];
      right_v[i] = (i == MaxElements - 1) ? '0 :
                   cell_q[(i == MaxElements - 1) ? i : i + 1];
    end
  end

  for (genvar g = 0; g < MaxElements; g++) begin : g_cell
    oets_cell u_cell (
      .clk_i   (clk_i),
      .cmd_i   (cmd[g]),
      .left_i  (left_v[g]),
      .right_i (right_v[g]),
      .value_o (cell_q[g])
    );
  end

  assign in_stall_o     = (state_q != ST_LOAD);
  assign out_valid_o    = (state_q == ST_EMIT);
  assign sorted_value_o = cell_q[0];
  assign last_o         = (state_q == ST_EMIT) && (phase_cnt_q == n_last);

  a_last_ends_set: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_acc && last_o && !cfg_we_i) |=> (state_q == ST_LOAD && !in_stall_o))
    else $error("Set did not return to loading after its last byte.");

  a_full_set_sorts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && load_cnt_q == n_last && !cfg_we_i) |=> (state_q == ST_SORT))
    else $error("Completed set did not start sorting.");

  a_phase_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_LOAD) |-> (phase_cnt_q < n_eff))
    else $error("Phase or emit count ran beyond the set size.");

  a_load_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_LOAD) |-> (load_cnt_q < n_eff))
    else $error("Load count ran beyond the set size.");

endmodule

@@ tb/sv/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Odd-even transposition sorter testbench
// Sends bytes to the sorter under several set sizes and handshake patterns.
// A model of the sorter collects each set, sorts it and queues the bytes it
// should return, and every returned byte and last flag is checked against the
// head of that queue.
// ----------------------------------------------------------------------------
module tb
  import oets_pkg::*;
();

  typedef struct packed {
    data_t value;
    logic  last;
  } sorted_byte_t;

  localparam int DrainCycles = 3 * MaxElements + 8;
  localparam int StuckLimit  = 4000;
  localparam int MaxGap      = 60;

  logic            clk_i;
  logic            rst_ni      = 1'b0;
  logic            cfg_we_i    = 1'b0;
  logic [CfgW-1:0] cfg_data_i  = '0;
  logic            in_valid_i  = 1'b0;
  logic            in_stall_o;
  logic [7:0]      value_i     = '0;
  logic            out_valid_o;
  logic            out_stall_i = 1'b0;
  logic [7:0]      sorted_value_o;
  logic            last_o;

  int              in_idle_pct   = 0;
  int              out_stall_pct = 0;
  int              errors        = 0;
  int              stuck_cycles  = 0;

  logic [CfgW-1:0] set_size_q = 5'd16;
  int              fill_count = 0;
  data_t           set_buf [MaxElements];
  sorted_byte_t    sorted_q [$];
  sorted_byte_t    head_byte;

  odd_even_transposition_sort i_dut (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_data_i,
    .in_valid_i,
    .in_stall_o,
    .value_i,
    .out_valid_o,
    .out_stall_i,
    .sorted_value_o,
    .last_o
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  function automatic int clamp_set_size(logic [CfgW-1:0] size);
    int n;
    n = int'(size);
    if (n == 0) n = 1;
    if (n > MaxElements) n = MaxElements;
    return n;
  endfunction

  // Stores one byte of the current set; the byte that completes the set runs
  // the transposition phases and queues the whole set in ascending order.
  function automatic void collect_byte(data_t v);
    int    n;
    int    i;
    int    ph;
    data_t tmp;
    sorted_byte_t item;
    n = clamp_set_size(set_size_q);
    set_buf[fill_count] = v;
    fill_count++;
    if (fill_count >= n) begin
      for (ph = 0; ph < n; ph++) begin
        for (i = ph % 2; i + 1 < n; i += 2) begin
          if (set_buf[i] > set_buf[i+1]) begin
            tmp          = set_buf[i];
            set_buf[i]   = set_buf[i+1];
            set_buf[i+1] = tmp;
          end
        end
      end
      for (i = 0; i < n; i++) begin
        item.value = set_buf[i];
        item.last  = (i == n - 1);
        sorted_q.push_back(item);
      end
      fill_count = 0;
    end
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    errors++;
    if (errors <= 100) begin
      $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (sorted_q.size() == 0) begin
        report_mismatch("result with nothing pending, sorted_value", sorted_value_o, -1);
      end else begin
        head_byte = sorted_q.pop_front();
        if (sorted_value_o !== head_byte.value) begin
          report_mismatch("sorted_value", sorted_value_o, head_byte.value);
        end
        if (last_o !== head_byte.last) begin
          report_mismatch("last", last_o, head_byte.last);
        end
      end
    end
    out_stall_i <= ($urandom_range(99) < out_stall_pct);
  end

  // The longest quiet stretch in a correct run is the pause before a size
  // change or a long run of output stalls; the limit sits far above both.
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || cfg_we_i) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles >= StuckLimit) begin
      $display("CHECKS FAILED");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  task automatic send_value(input data_t v);
    int gap;
    gap = 0;
    while (gap < MaxGap && $urandom_range(99) < in_idle_pct) gap++;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    value_i    <= v;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    collect_byte(v);
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (sorted_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_set_size(input logic [CfgW-1:0] size);
    wait_drained();
    cfg_we_i   <= 1'b1;
    cfg_data_i <= size;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    set_size_q = size;
    fill_count = 0;
  endtask

  task automatic send_set(input int count);
    int    i;
    int    shape;
    data_t base;
    shape = $urandom_range(0, 9);
    base  = data_t'($urandom_range(0, 255));
    for (i = 0; i < count; i++) begin
      case (shape)
        0: send_value(base + data_t'(i));
        1: send_value(base - data_t'(i));
        2: send_value(base ^ data_t'($urandom_range(0, 1)));
        default: send_value(data_t'($urandom_range(0, 255)));
      endcase
    end
  endtask

  task automatic test_reset_size();
    int i;
    for (i = 0; i < MaxElements; i++) begin
      send_value(data_t'(8'hFF - i * 17));
    end
  endtask

  task automatic test_zero_size();
    write_set_size(5'd0);
    send_value(8'hAA);
    send_value(8'h55);
  endtask

  task automatic test_one_and_two();
    write_set_size(5'd1);
    send_value(8'h00);
    write_set_size(5'd2);
    send_value(8'hFF);
    send_value(8'h00);
  endtask

  task automatic test_discard_partial();
    write_set_size(5'd3);
    send_value(8'hC3);
    send_value(8'h3C);
    write_set_size(5'd3);
    send_value(8'h09);
    send_value(8'h09);
    send_value(8'h03);
  endtask

  task automatic test_oversize();
    write_set_size(5'd31);
    send_set(MaxElements);
    write_set_size(5'd17);
    send_set(MaxElements);
  endtask

  task automatic test_random(input int in_pct, input int out_pct, input int items);
    int sent;
    int sets;
    int n;
    int pick;
    logic [CfgW-1:0] size;
    in_idle_pct   = in_pct;
    out_stall_pct = out_pct;
    sent = 0;
    while (sent < items) begin
      pick = $urandom_range(0, 19);
      if (pick == 0) size = 5'd0;
      else if (pick == 1) size = CfgW'($urandom_range(MaxElements + 1, 31));
      else if (pick == 2) size = CfgW'(MaxElements);
      else if (pick < 6) size = CfgW'($urandom_range(9, MaxElements - 1));
      else size = CfgW'($urandom_range(1, 8));
      write_set_size(size);
      n = clamp_set_size(size);
      for (sets = $urandom_range(1, 3); sets > 0; sets--) begin
        send_set(n);
        sent += n;
      end
      if (n > 1 && $urandom_range(0, 4) == 0) begin
        pick = $urandom_range(1, n - 1);
        send_set(pick);
        sent += pick;
      end
    end
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_size();
    test_zero_size();
    test_one_and_two();
    test_discard_partial();
    test_oversize();
    test_random(0, 0, 45);
    test_random(85, 0, 45);
    test_random(0, 85, 45);
    test_random(18, 18, 45);
    wait_drained();
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

@@ files.f @@
hdl/oets_pkg.sv
hdl/oets_cell.sv
hdl/odd_even_transposition_sort.sv
tb/sv/tb.sv
